FILE: src/vwct_pkg.sv
// Shared types, constants and helpers for the vote window confidence tracker.
// No dependencies; every other file in src refers to it by scoped names.

package vwct_pkg;

	// Hash constants (all arithmetic modulo 2^64)
	localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
	localparam logic [63:0] FIB_MUL = 64'd11400714819323198485;

	localparam int unsigned HALF_W = 32;
	localparam logic [HALF_W-1:0] LCG_MUL_LO = LCG_MUL[HALF_W-1:0];
	localparam logic [HALF_W-1:0] LCG_MUL_HI = LCG_MUL[63:HALF_W];
	localparam logic [HALF_W-1:0] FIB_MUL_LO = FIB_MUL[HALF_W-1:0];
	localparam logic [HALF_W-1:0] FIB_MUL_HI = FIB_MUL[63:HALF_W];

	localparam int unsigned ID_W   = 64;
	localparam int unsigned ERR_W  = 32;
	localparam int unsigned HASH_W = 16;
	localparam int unsigned HASH_LSB = 48;

	// Recent voter filter
	localparam int unsigned FILTER_DEPTH = 8;
	localparam int unsigned SLOT_W = $clog2(FILTER_DEPTH);

	// Vote windows
	localparam int unsigned WIN_W  = 8;
	localparam int unsigned CNT8_W = $clog2(WIN_W + 1);
	localparam logic [CNT8_W-1:0] QUORUM = CNT8_W'(6);
	localparam logic [WIN_W-1:0] YES_WIN_RESET = 8'hAA;

	// Confidence count
	localparam int unsigned COUNT_W = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] FIN_SCORE_RESET = COUNT_W'(128);

	// Configuration port
	localparam int unsigned CFG_DATA_W = 64;
	typedef enum logic [0:0] {
		REG_HASH_SEED = 1'b0,
		REG_FIN_SCORE = 1'b1
	} cfg_reg_t;

	// Item handed from the hash pipeline to the state stage
	typedef struct packed {
		logic              bypass;     // no-node id: skip the duplicate filter
		logic [HASH_W-1:0] hash;
		logic              vote_yes;   // error code was zero
		logic              vote_cons;  // sign bit clear: vote is conclusive
	} hitem_t;

	function automatic logic [CNT8_W-1:0] ones8(input logic [WIN_W-1:0] v);
		logic [CNT8_W-1:0] n;
		n = '0;
		for (int b = 0; b < WIN_W; b++) begin
			n = n + CNT8_W'(v[b]);
		end
		return n;
	endfunction

endpackage

FILE: src/vote_window_confidence_tracker.sv
// A vote passes the input register, 3 hash stages and the result register to give its result.
// Throughput: one vote per cycle if not stalled; the hash pipeline and state update never iterate.
// The input side keeps taking votes while a result waits, until the pipeline bubbles fill.
// Reset (arst_n low, asynchronous): empty pipeline, filter ring all zero, write slot 0,
// yes window 0xAA, considered window 0, confidence 0, hash seed 0, finalization score 128.
// Depends on vwct_pkg, vwct_hash and vwct_state.

module vote_window_confidence_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes: the user writes only while the block is idle (not enforced)
	input  logic                                cfg_we,
	input  vwct_pkg::cfg_reg_t                  cfg_index,
	input  logic [vwct_pkg::CFG_DATA_W-1:0]     cfg_data,
	// vote channel
	input  logic                                vote_valid,
	output logic                                vote_ready,
	input  logic signed [vwct_pkg::ID_W-1:0]    voter_id,
	input  logic [vwct_pkg::ERR_W-1:0]          error_code,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                duplicate_voter,
	output logic                                status_changed,
	output logic                                accepted_now,
	output logic [vwct_pkg::COUNT_W-1:0]        agreement_count
);

	logic [vwct_pkg::ID_W-1:0]    hash_seed_q;
	logic [vwct_pkg::COUNT_W-1:0] fin_score_q;

	logic             hitem_valid;
	logic             hitem_ready;
	vwct_pkg::hitem_t hitem;

	// Configuration registers. The seed feeds the hash multipliers directly, so it
	// must not change while a vote is still in the pipeline; only the user keeps writes idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= '0;
			fin_score_q <= vwct_pkg::FIN_SCORE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vwct_pkg::REG_HASH_SEED: hash_seed_q <= cfg_data;
				vwct_pkg::REG_FIN_SCORE: fin_score_q <= cfg_data[vwct_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Hash pipeline: register the vote, form the 32x32 partial products of both
	// 64-bit products, sum them per product, then add the two and keep the top
	// 16 bits. Each stage advances on its own so a bubble closes up under a stall.
	vwct_hash u_hash (
		.clk         (clk),
		.arst_n      (arst_n),
		.vote_valid  (vote_valid),
		.vote_ready  (vote_ready),
		.voter_id    (voter_id),
		.error_code  (error_code),
		.hash_seed   (hash_seed_q),
		.hitem_valid (hitem_valid),
		.hitem_ready (hitem_ready),
		.hitem       (hitem)
	);

	// State stage: match the hash against the ring (oldest slot left out), shift
	// the windows, update the confidence and load the result register in the same cycle.
	// State changes only as an item enters the result register, so votes are
	// applied strictly in arrival order.
	vwct_state u_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.hitem_valid     (hitem_valid),
		.hitem_ready     (hitem_ready),
		.hitem           (hitem),
		.fin_score       (fin_score_q),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.duplicate_voter (duplicate_voter),
		.status_changed  (status_changed),
		.accepted_now    (accepted_now),
		.agreement_count (agreement_count)
	);

endmodule

FILE: src/vwct_hash.sv
// Input register and three-stage pipeline that forms the 16-bit voter hash.
// Depends on vwct_pkg for constants and the hitem_t type.

module vwct_hash (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vote_valid,
	output logic                           vote_ready,
	input  logic signed [vwct_pkg::ID_W-1:0]  voter_id,
	input  logic        [vwct_pkg::ERR_W-1:0] error_code,
	input  logic        [vwct_pkg::ID_W-1:0]  hash_seed,
	output logic                           hitem_valid,
	input  logic                           hitem_ready,
	output vwct_pkg::hitem_t               hitem
);

	localparam int unsigned HW = vwct_pkg::HALF_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [vwct_pkg::ID_W-1:0] id_s1;
	logic yes_s1, cons_s1;

	logic [63:0] l1_s2, l2_s2;
	logic [HW-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2;
	logic bypass_s2, yes_s2, cons_s2;

	logic [63:0] r1_s3, r2_s3;
	logic bypass_s3, yes_s3, cons_s3;

	logic [vwct_pkg::HASH_W-1:0] hash_s4;
	logic bypass_s4, yes_s4, cons_s4;

	logic [63:0] xid;
	logic [63:0] lcg_ll, lcg_hl, lcg_lh, fib_ll, fib_hl, fib_lh;
	logic [63:0] sum_r;

	// a stage may load when empty or when its content moves on
	assign rdy_s4 = !v_s4 || hitem_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign vote_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= vote_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// low halves of 64x64 products mod 2^64, split into 32x32 pieces
	always_comb begin
		xid    = id_s1 ^ hash_seed;
		lcg_ll = 64'(vwct_pkg::LCG_MUL_LO) * 64'(id_s1[HW-1:0]);
		lcg_hl = 64'(vwct_pkg::LCG_MUL_HI) * 64'(id_s1[HW-1:0]);
		lcg_lh = 64'(vwct_pkg::LCG_MUL_LO) * 64'(id_s1[63:HW]);
		fib_ll = 64'(vwct_pkg::FIB_MUL_LO) * 64'(xid[HW-1:0]);
		fib_hl = 64'(vwct_pkg::FIB_MUL_HI) * 64'(xid[HW-1:0]);
		fib_lh = 64'(vwct_pkg::FIB_MUL_LO) * 64'(xid[63:HW]);
		sum_r  = r1_s3 + r2_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vote_valid) begin
			id_s1   <= $unsigned(voter_id);
			yes_s1  <= (error_code == '0);
			cons_s1 <= !error_code[vwct_pkg::ERR_W-1];
		end
		if (rdy_s2 && v_s1) begin
			l1_s2     <= lcg_ll;
			m1a_s2    <= lcg_hl[HW-1:0];
			m1b_s2    <= lcg_lh[HW-1:0];
			l2_s2     <= fib_ll;
			m2a_s2    <= fib_hl[HW-1:0];
			m2b_s2    <= fib_lh[HW-1:0];
			bypass_s2 <= &id_s1;
			yes_s2    <= yes_s1;
			cons_s2   <= cons_s1;
		end
		if (rdy_s3 && v_s2) begin
			r1_s3     <= l1_s2 + {m1a_s2 + m1b_s2, {HW{1'b0}}} + vwct_pkg::LCG_ADD;
			r2_s3     <= l2_s2 + {m2a_s2 + m2b_s2, {HW{1'b0}}};
			bypass_s3 <= bypass_s2;
			yes_s3    <= yes_s2;
			cons_s3   <= cons_s2;
		end
		if (rdy_s4 && v_s3) begin
			hash_s4   <= sum_r[vwct_pkg::HASH_LSB +: vwct_pkg::HASH_W];
			bypass_s4 <= bypass_s3;
			yes_s4    <= yes_s3;
			cons_s4   <= cons_s3;
		end
	end

	assign hitem_valid     = v_s4;
	assign hitem.bypass    = bypass_s4;
	assign hitem.hash      = hash_s4;
	assign hitem.vote_yes  = yes_s4;
	assign hitem.vote_cons = cons_s4;

endmodule

FILE: src/vwct_state.sv
// Duplicate filter ring, vote windows, confidence word and result register.
// Depends on vwct_pkg for constants, the hitem_t type and ones8().

module vwct_state (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hitem_valid,
	output logic                           hitem_ready,
	input  vwct_pkg::hitem_t               hitem,
	input  logic [vwct_pkg::COUNT_W-1:0]   fin_score,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           duplicate_voter,
	output logic                           status_changed,
	output logic                           accepted_now,
	output logic [vwct_pkg::COUNT_W-1:0]   agreement_count
);

	logic [vwct_pkg::HASH_W-1:0] ring_q [vwct_pkg::FILTER_DEPTH];
	logic [vwct_pkg::SLOT_W-1:0] slot_q;
	logic [vwct_pkg::WIN_W-1:0]  yes_win_q, cons_win_q;
	logic                        acc_q;
	logic [vwct_pkg::COUNT_W-1:0] cnt_q;

	logic                        out_valid_q;
	logic                        dup_q, changed_q;

	logic take, hit, dup;
	logic [vwct_pkg::WIN_W-1:0]  yes_win_n, cons_win_n;
	logic yes_rnd, no_rnd;
	logic acc_n, changed;
	logic [vwct_pkg::COUNT_W-1:0] cnt_n, cnt_inc;
	logic [vwct_pkg::SLOT_W-1:0]  slot_inc;

	assign hitem_ready = !out_valid_q || result_ready;
	assign take = hitem_valid && hitem_ready;

	always_comb begin
		// search every slot but the oldest, which is about to be overwritten
		hit = 1'b0;
		for (int i = 0; i < vwct_pkg::FILTER_DEPTH; i++) begin
			if ((vwct_pkg::SLOT_W'(i) != slot_q) && (ring_q[i] == hitem.hash)) begin
				hit = 1'b1;
			end
		end
		dup = hit && !hitem.bypass;

		slot_inc = (slot_q == vwct_pkg::SLOT_W'(vwct_pkg::FILTER_DEPTH - 1)) ?
			'0 : slot_q + 1'b1;

		yes_win_n  = {yes_win_q[vwct_pkg::WIN_W-2:0], hitem.vote_yes};
		cons_win_n = {cons_win_q[vwct_pkg::WIN_W-2:0], hitem.vote_cons};
		yes_rnd = vwct_pkg::ones8(yes_win_n & cons_win_n) > vwct_pkg::QUORUM;
		no_rnd  = vwct_pkg::ones8(~yes_win_n & cons_win_n) > vwct_pkg::QUORUM;

		cnt_inc = cnt_q + 1'b1;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		changed = 1'b0;
		if (!dup && (yes_rnd || no_rnd)) begin
			if (acc_q == yes_rnd) begin
				if (cnt_q != vwct_pkg::COUNT_MAX) begin
					cnt_n   = cnt_inc;
					changed = (cnt_inc == fin_score);
				end
			end else begin
				acc_n   = yes_rnd;
				cnt_n   = '0;
				changed = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vwct_pkg::FILTER_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q      <= '0;
			yes_win_q   <= vwct_pkg::YES_WIN_RESET;
			cons_win_q  <= '0;
			acc_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				if (!dup) begin
					yes_win_q  <= yes_win_n;
					cons_win_q <= cons_win_n;
					acc_q      <= acc_n;
					cnt_q      <= cnt_n;
					if (!hitem.bypass) begin
						ring_q[slot_q] <= hitem.hash;
						slot_q         <= slot_inc;
					end
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dup_q     <= dup;
			changed_q <= changed;
		end
	end

	assign result_valid    = out_valid_q;
	assign duplicate_voter = dup_q;
	assign status_changed  = changed_q;
	// confidence registers hold the value after the item in the result register
	assign accepted_now    = acc_q;
	assign agreement_count = cnt_q;

endmodule

FILE: src/vwct_checker.sv
// Port-level checks for vote_window_confidence_tracker, bound to the top level.
// Depends on vwct_pkg for port types and widths.

module vwct_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  vwct_pkg::cfg_reg_t                  cfg_index,
	input  logic [vwct_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                vote_valid,
	input  logic                                vote_ready,
	input  logic signed [vwct_pkg::ID_W-1:0]    voter_id,
	input  logic [vwct_pkg::ERR_W-1:0]          error_code,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic                                duplicate_voter,
	input  logic                                status_changed,
	input  logic                                accepted_now,
	input  logic [vwct_pkg::COUNT_W-1:0]        agreement_count
);

	// a rejected vote never changes the status
	a_dup_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && duplicate_voter |-> !status_changed)
		else $error("duplicate vote reported a status change");

	// with the result register empty the whole pipeline must accept
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> vote_ready)
		else $error("vote channel stalled with no result pending");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(duplicate_voter) &&
		$stable(status_changed) && $stable(accepted_now) && $stable(agreement_count))
		else $error("result changed while stalled");

	// a flip to the other outcome restarts the count
	a_flip_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready ##1 result_valid && status_changed &&
		(accepted_now != $past(accepted_now)) |-> agreement_count == '0)
		else $error("acceptance flipped without clearing the count");

endmodule

bind vote_window_confidence_tracker vwct_checker u_vwct_checker (.*);
